/* sv/ise_pkg.sv */
// Shared constants for the interpolation search engine and its checker.
// Depends on nothing; every other file imports it.
package ise_pkg;

  // Default sizes for the top-level parameters.
  localparam int TableDepthDef = 1024;
  localparam int WordBitsDef   = 32;

  // Fixed field widths.
  localparam int IDX_W = 10;         // entry_index, range_start
  localparam int POS_W = 11;         // position, range_stop
  localparam int IX_W  = POS_W + 1;  // signed working bounds (hi may reach -1)
  localparam int CNT_W = $clog2(IDX_W + 1);

  localparam int OUT_DATA_W = ((POS_W + 7) / 8) * 8;

  // Command codes carried in s_axis_tuser.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_RANGE_START = 1'b0;
  localparam logic REG_RANGE_STOP  = 1'b1;

  localparam logic [IDX_W-1:0] RangeStartRst = '0;
  localparam logic [POS_W-1:0] RangeStopRst  = POS_W'(2 ** IDX_W);

endpackage

/* sv/interpolation_search_engine.sv */
// Interpolation search engine: a table memory, a probe sequencer and a shared
// multiply / restoring-divide unit. Depends on ise_pkg.
//
// Usage. Items arrive on the s_axis channel; s_axis_tuser holds the command
// (write entry or search) and s_axis_tdata holds entry_index and word. A write
// item stores word at entry_index and gives no result. A search
// item looks for the key word in the index range [range_start, range_stop),
// both set through the APB port, and gives one result item on m_axis:
// m_axis_tuser is found, m_axis_tdata is the 1-based position (0 if absent).
// One item is in flight at a time. A search is accepted, runs its probes and
// ends with the output load. Each probe checks the range, reads the two end
// values, multiplies, takes ten divide steps, reads the probed entry and
// compares; a probe whose end values are equal skips the multiply and divide.
// A search also ends on an empty range or on a key outside the end values.
// The ten divide steps of the restoring divider dominate. Reset clears the
// control state and sets the range to [0, 1024); the table holds no valid
// data until written. A finished result sits in the output register; while the
// receiver stalls the engine accepts a further write or search, and a second
// search waits at its end until the output register frees up.
module interpolation_search_engine
  import ise_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int WORD_BITS   = WordBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input items
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: entry_index[IDX_W-1:0], word, zero padding
  input  logic [((IDX_W + WORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: cmd
  input  logic s_axis_tuser,
  // Result items
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: position[POS_W-1:0], zero padding
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: found
  output logic m_axis_tuser,
  // Configuration
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int StopMax = (TABLE_DEPTH < 2 ** IDX_W) ? TABLE_DEPTH : 2 ** IDX_W;
  localparam logic [POS_W-1:0] StopCap = POS_W'(StopMax);
  localparam logic [WORD_BITS-1:0] SignMask = {1'b1, {(WORD_BITS - 1){1'b0}}};

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_LD_LO = 4'd2;
  localparam logic [3:0] ST_LD_HI = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_MID   = 4'd6;
  localparam logic [3:0] ST_PROBE = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  logic [3:0] state_q, state_d;

  logic [IDX_W-1:0] range_start_q;
  logic [POS_W-1:0] range_stop_q;

  logic signed [IX_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [WORD_BITS-1:0] key_q, key_d, vlo_q, vlo_d;
  logic [WORD_BITS-1:0] a_q, a_d, d_q, d_d, rem_q, rem_d;
  logic [IDX_W-1:0] n_q, n_d, div_q, div_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic found_q, found_d;
  logic [POS_W-1:0] pos_q, pos_d;

  logic out_valid_q;
  logic out_found_q;
  logic [POS_W-1:0] out_pos_q;
  logic out_load;

  logic [WORD_BITS-1:0] mem [TABLE_DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic [AW-1:0] mem_addr;
  logic mem_we;

  logic in_accept;
  logic [IDX_W-1:0] in_idx;
  logic [WORD_BITS-1:0] in_word_b;
  logic [POS_W-1:0] stop_clip;
  logic [WORD_BITS+IDX_W-1:0] prod;
  logic [WORD_BITS:0] trial, trial_diff;
  logic trial_ge;
  logic signed [IX_W-1:0] mid_calc;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= RangeStartRst;
      range_stop_q  <= RangeStopRst;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_RANGE_START) begin
        range_start_q <= pwdata[IDX_W-1:0];
      end else begin
        range_stop_q <= pwdata[POS_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_RANGE_START) begin
      prdata = APB_DW'(range_start_q);
    end else begin
      prdata = APB_DW'(range_stop_q);
    end
  end

  // Input unpacking; entries and keys are kept in offset binary.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[IDX_W-1:0];
  assign in_word_b     = s_axis_tdata[IDX_W+WORD_BITS-1:IDX_W] ^ SignMask;
  assign stop_clip     = (range_stop_q > StopCap) ? StopCap : range_stop_q;

  // Shared arithmetic: one product, one restoring divide step, the probe index.
  assign prod       = a_q * n_q;
  assign trial      = {rem_q, div_q[IDX_W-1]};
  assign trial_diff = trial - {1'b0, d_q};
  assign trial_ge   = (trial >= {1'b0, d_q});
  assign mid_calc   = lo_q + IX_W'(div_q);

  // Probe sequencer.
  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    key_d    = key_q;
    vlo_d    = vlo_q;
    a_d      = a_q;
    d_d      = d_q;
    n_d      = n_q;
    rem_d    = rem_q;
    div_d    = div_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    pos_d    = pos_q;
    mem_addr = AW'(in_idx);
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser == CMD_WRITE) begin
            mem_we = (32'(in_idx) < TABLE_DEPTH);
          end else begin
            key_d   = in_word_b;
            lo_d    = IX_W'(range_start_q);
            hi_d    = IX_W'(stop_clip) - IX_W'(1);
            found_d = 1'b0;
            pos_d   = '0;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        mem_addr = AW'(lo_q[IDX_W-1:0]);
        if (lo_q > hi_q) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_LD_LO;
        end
      end
      ST_LD_LO: begin
        mem_addr = AW'(hi_q[IDX_W-1:0]);
        vlo_d    = rdata_q;
        state_d  = ST_LD_HI;
      end
      ST_LD_HI: begin
        // The key lies outside the end values: not present.
        mem_addr = AW'(lo_q[IDX_W-1:0]);
        if (key_q < vlo_q || key_q > rdata_q) begin
          state_d = ST_FIN;
        end else if (rdata_q == vlo_q) begin
          mid_d   = lo_q;
          state_d = ST_PROBE;
        end else begin
          a_d     = key_q - vlo_q;
          d_d     = rdata_q - vlo_q;
          n_d     = IDX_W'(hi_q - lo_q);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // Upper product bits are below the divisor since a <= d.
        rem_d   = prod[WORD_BITS+IDX_W-1:IDX_W];
        div_d   = prod[IDX_W-1:0];
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = trial_ge ? trial_diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
        div_d = {div_q[IDX_W-2:0], trial_ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(IDX_W - 1)) begin
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        mem_addr = AW'(mid_calc[IDX_W-1:0]);
        mid_d    = mid_calc;
        state_d  = ST_PROBE;
      end
      ST_PROBE: begin
        if (rdata_q > key_q) begin
          hi_d    = mid_q - IX_W'(1);
          state_d = ST_CHECK;
        end else if (rdata_q < key_q) begin
          lo_d    = mid_q + IX_W'(1);
          state_d = ST_CHECK;
        end else begin
          found_d = 1'b1;
          pos_d   = mid_q[POS_W-1:0] + POS_W'(1);
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lo_q    <= '0;
      hi_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q   <= mid_d;
    key_q   <= key_d;
    vlo_q   <= vlo_d;
    a_q     <= a_d;
    d_q     <= d_d;
    n_q     <= n_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  // Table memory, one port, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= in_word_b;
    end
    rdata_q <= mem[mem_addr];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= found_q;
      out_pos_q   <= pos_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_pos_q);

endmodule

/* sv/ise_checker.sv */
// Port-level checks for the interpolation search engine, bound to the top level.
// Depends on ise_pkg and interpolation_search_engine.
module ise_checker
  import ise_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic m_axis_tuser
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its fields.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  // Found and position agree: a miss reports position zero, a hit does not.
  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == 1'b1) == (m_axis_tdata != '0)))
    else $error("found flag and position disagree");

  // A write item never produces a result item.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_WRITE |=> !$rose(m_axis_tvalid))
    else $error("result item after a write");

  // An accepted search closes the input.
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_SEARCH |=> !s_axis_tready)
    else $error("input accepted during a search");

endmodule

bind interpolation_search_engine ise_checker u_ise_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for interpolation_search_engine: table loads and key searches
// on the item stream, range setup on the APB port, results checked against a local predictor.
// Depends on ise_pkg and on the engine RTL.
module tb;
  import ise_pkg::*;

  localparam int IN_DATA_W    = ((IDX_W + WordBitsDef + 7) / 8) * 8;
  localparam int ItemGoal     = 1700;
  localparam int CycleLimit   = 3_000_000;
  localparam int SettleCycles = 40;
  localparam int WordMin      = 32'h8000_0000;
  localparam int WordMax      = 32'h7fff_ffff;

  typedef struct {
    logic             cmd;
    logic [IDX_W-1:0] index;
    int               word;
  } req_t;

  typedef struct {
    logic             found;
    logic [POS_W-1:0] position;
  } hit_t;

  typedef enum int {
    FILL_RAMP, FILL_SKEW, FILL_DUPES, FILL_EXTREMES, FILL_FLAT, FILL_SCRAMBLE
  } fill_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  // Stimulus backlog, expected search outcomes, and the table as the predictor sees it.
  req_t cmd_backlog[$];
  hit_t hits_due[$];
  int   word_tbl[TableDepthDef];
  int   plan_tbl[TableDepthDef];
  int   start_reg = 0;
  int   stop_reg = 1024;

  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_writes = 0;
  int   n_searches = 0;
  int   n_hits = 0;
  int   n_misses = 0;
  int   n_mismatch = 0;
  int   n_settings = 0;
  int   cycles = 0;
  logic in_taken = 1'b0;
  int   gap_left = 0;
  int   burst_left = 1;
  int   rx_cnt = 0;

  interpolation_search_engine #(
    .TABLE_DEPTH(TableDepthDef),
    .WORD_BITS  (WordBitsDef)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  // Saturate a wide value into the signed word range.
  function automatic int clamp_word(input longint v);
    if (v > longint'(WordMax)) return WordMax;
    if (v < longint'(WordMin)) return WordMin;
    return int'(v);
  endfunction

  // Interpolation search over the current range of the shadow table.
  function automatic hit_t probe_search(input int key);
    int     lo;
    int     hi;
    int     mid;
    bit     done;
    longint num;
    longint den;
    hit_t   r;
    r.found = 1'b0;
    r.position = '0;
    done = 1'b0;
    lo = start_reg;
    hi = ((stop_reg > TableDepthDef) ? TableDepthDef : stop_reg) - 1;
    while (!done && lo <= hi) begin
      if (key < word_tbl[lo] || key > word_tbl[hi]) begin
        done = 1'b1;
      end else begin
        if (word_tbl[hi] == word_tbl[lo]) begin
          mid = lo;
        end else begin
          num = (longint'(key) - longint'(word_tbl[lo])) * longint'(hi - lo);
          den = longint'(word_tbl[hi]) - longint'(word_tbl[lo]);
          mid = lo + int'(num / den);
        end
        if (word_tbl[mid] > key) begin
          hi = mid - 1;
        end else if (word_tbl[mid] < key) begin
          lo = mid + 1;
        end else begin
          r.found = 1'b1;
          r.position = POS_W'(mid + 1);
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Sender: bursts of items separated by random gaps, some bursts back to back.
  always @(negedge clk_i) begin
    req_t nxt;
    if (s_axis_tvalid && !in_taken) begin
      // Item still waiting for the handshake.
    end else if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (cmd_backlog.size() > 0) begin
      nxt = cmd_backlog.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= nxt.cmd;
      s_axis_tdata  <= {{(IN_DATA_W - IDX_W - WordBitsDef){1'b0}}, nxt.word, nxt.index};
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(20, 40);
        else if ($urandom_range(0, 2) == 0) gap_left = 0;
        else gap_left = $urandom_range(1, 8);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: cycles through always ready, coin flips, long stalls and sparse accepts.
  always @(negedge clk_i) begin
    rx_cnt = rx_cnt + 1;
    case ((rx_cnt >> 7) & 3)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ((rx_cnt & 15) == 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Result checking first, then prediction for the item accepted at this edge.
  always @(posedge clk_i) begin
    hit_t             want;
    logic [IDX_W-1:0] idx;
    int               w;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hits_due.size() == 0) begin
          if (n_mismatch < 10)
            $display("%0t: result with nothing expected: found=%0b position=%0d",
                     $realtime, m_axis_tuser, m_axis_tdata[POS_W-1:0]);
          n_mismatch++;
        end else begin
          want = hits_due.pop_front();
          if (want.found !== m_axis_tuser || want.position !== m_axis_tdata[POS_W-1:0]) begin
            if (n_mismatch < 10)
              $display("%0t: mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                       $realtime, want.found, want.position, m_axis_tuser,
                       m_axis_tdata[POS_W-1:0]);
            n_mismatch++;
          end
          if (want.found) n_hits++;
          else n_misses++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        idx = s_axis_tdata[IDX_W-1:0];
        w = s_axis_tdata[IDX_W+WordBitsDef-1:IDX_W];
        n_accepted++;
        if (s_axis_tuser == CMD_WRITE) begin
          word_tbl[idx] = w;
          n_writes++;
        end else begin
          hits_due.push_back(probe_search(w));
          n_searches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("interpolation_search_engine test failed");
      $finish;
    end
  end

  task automatic queue_item(input logic cmd, input int idx, input int w);
    req_t r;
    r.cmd = cmd;
    r.index = IDX_W'(idx);
    r.word = w;
    if (cmd == CMD_WRITE) plan_tbl[idx] = w;
    cmd_backlog.push_back(r);
    n_queued++;
  endtask

  // Wait until every queued item is taken and every search has answered.
  task automatic settle();
    do @(negedge clk_i);
    while (n_accepted != n_queued || hits_due.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic reg_sel, input int value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_RANGE_START) start_reg = value & 32'h3ff;
    else stop_reg = value & 32'h7ff;
  endtask

  task automatic set_range(input int first, input int stop);
    apb_write(REG_RANGE_START, first);
    apb_write(REG_RANGE_STOP, stop);
    n_settings++;
  endtask

  // Rewrite a window of the table with one value profile.
  task automatic load_window(input int s, input int n, input fill_e kind);
    longint v;
    v = longint'(int'($urandom)) / 2;
    for (int i = 0; i < n; i++) begin
      case (kind)
        FILL_RAMP:     v = v + $urandom_range(1, 1 << 20);
        FILL_SKEW:     v = v + (longint'(1) << ((i * 30) / n)) + $urandom_range(0, 3);
        FILL_DUPES:    if ($urandom_range(0, 9) < 3) v = v + $urandom_range(1, 1000);
        FILL_EXTREMES: v = (i < n / 2) ? longint'(WordMin) + i : longint'(WordMax) - (n - 1 - i);
        FILL_FLAT:     v = v;
        default:       v = longint'(int'($urandom));
      endcase
      queue_item(CMD_WRITE, s + i, clamp_word(v));
    end
  endtask

  // Searches with keys mostly taken from the window, plus near misses, outliers,
  // random keys, and a few writes that disturb or refresh the window.
  task automatic queue_searches(input int s, input int n, input int count);
    int r;
    int j;
    int key;
    int lo_v;
    int hi_v;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      j = s + $urandom_range(0, n - 1);
      lo_v = plan_tbl[s];
      hi_v = plan_tbl[s + n - 1];
      if (r < 3) begin
        queue_item(CMD_WRITE, j, int'($urandom));
      end else if (r < 6) begin
        queue_item(CMD_WRITE, j, plan_tbl[j]);
      end else begin
        if (r < 55) key = plan_tbl[j];
        else if (r < 70) key = clamp_word(longint'(plan_tbl[j]) + (r[0] ? 1 : -1));
        else if (r < 80) key = int'($urandom);
        else if (r < 90) key = r[0] ? clamp_word(longint'(lo_v) - 1) : clamp_word(longint'(hi_v) + 1);
        else if (hi_v > lo_v)
          key = clamp_word(longint'(lo_v) +
                           longint'($urandom) % (longint'(hi_v) - longint'(lo_v) + 1));
        else key = lo_v;
        queue_item(CMD_SEARCH, $urandom_range(0, TableDepthDef - 1), key);
      end
    end
  endtask

  initial begin
    int    s;
    int    n;
    int    stop;
    int    ph;
    longint v;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a four-entry table spanning the whole word range.
    set_range(0, 4);
    queue_item(CMD_WRITE, 0, WordMin);
    queue_item(CMD_WRITE, 1, -5);
    queue_item(CMD_WRITE, 2, 7);
    queue_item(CMD_WRITE, 3, WordMax);
    queue_item(CMD_SEARCH, 0, WordMin);
    queue_item(CMD_SEARCH, 1023, WordMax);
    queue_item(CMD_SEARCH, 512, 7);
    queue_item(CMD_SEARCH, 341, 0);
    queue_item(CMD_SEARCH, 682, -6);
    settle();

    // Equal end values, then keys just below and just above the range.
    set_range(4, 6);
    queue_item(CMD_WRITE, 4, 9);
    queue_item(CMD_WRITE, 5, 9);
    queue_item(CMD_SEARCH, 0, 9);
    queue_item(CMD_SEARCH, 0, 8);
    queue_item(CMD_SEARCH, 0, 10);
    settle();

    // Empty range.
    set_range(5, 5);
    queue_item(CMD_SEARCH, 0, 9);
    settle();

    // Out-of-order table: the search must still terminate.
    set_range(0, 4);
    queue_item(CMD_WRITE, 1, 100);
    queue_item(CMD_SEARCH, 0, 7);
    queue_item(CMD_SEARCH, 0, 100);
    settle();

    // Fill the whole table with an ascending ramp and search all of it.
    set_range(0, 1024);
    v = longint'(WordMin);
    for (int i = 0; i < TableDepthDef; i++) begin
      queue_item(CMD_WRITE, i, (i == TableDepthDef - 1) ? WordMax : clamp_word(v));
      v = v + $urandom_range(1, 4_200_000);
    end
    queue_searches(0, TableDepthDef, 80);

    // Random windows with varied profiles; the sender pauses for each new setting.
    ph = 0;
    while (n_queued < ItemGoal) begin
      settle();
      if (ph % 6 == 2) begin
        // Last entry alone, stop clipped to the table depth.
        s = TableDepthDef - 1;
        n = 1;
        stop = 2047;
      end else if (ph % 6 == 4) begin
        s = $urandom_range(0, TableDepthDef - 1);
        n = 0;
        stop = (ph == 4) ? 0 : $urandom_range(0, s);
      end else begin
        n = $urandom_range(2, 48);
        if (ph % 6 == 5) begin
          s = TableDepthDef - n;
          stop = 2047;
        end else begin
          s = $urandom_range(0, TableDepthDef - n);
          stop = s + n;
        end
      end
      set_range(s, stop);
      if (n > 0) begin
        load_window(s, n, fill_e'($urandom_range(0, 5)));
        queue_searches(s, n, 30);
      end else begin
        queue_searches(s, 1, 10);
      end
      ph++;
    end
    settle();

    if (hits_due.size() != 0) n_mismatch++;
    $display("Run covered %0d table writes and %0d searches over %0d range settings.",
             n_writes, n_searches, n_settings);
    $display("Searches: %0d found, %0d not found; %0d mismatches.",
             n_hits, n_misses, n_mismatch);
    if (n_mismatch == 0) begin
      $display("interpolation_search_engine test passed");
    end else begin
      $display("interpolation_search_engine test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ise_pkg.sv
sv/interpolation_search_engine.sv
sv/ise_checker.sv
tb/sv/tb.sv
